FILE: hw/rtl/oli_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Word types for the request and response channels, and operation codes.
// ----------------------------------------------------------------------------
package oli_pkg;

   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] found_position;
      logic [POS_W-1:0] list_count;
   } rsp_type;

endpackage

FILE: hw/rtl/ordered_list_insert_delete_find.sv
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and find
// For a list of n words: an insert at p moves m = n - p + 1 words one place up, a delete
// moves m = n - p words one place down, and a find walks from the front and stops at its
// first match. One word at a time: the next is taken as the response leaves, and the
// receiver cannot stall. Reset clears the list length; the store needs no clearing.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_find #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  oli_pkg::req_type req_data,
   output logic             rsp_valid,
   output oli_pkg::rsp_type rsp_data
);

   // Address width of the store, width of the length counter, and a compare
   // width wide enough for both the length and the request position plus one.
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > oli_pkg::POS_W) ? LW : oli_pkg::POS_W) + 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INS  = 2'd1;
   localparam logic [1:0] ST_DEL  = 2'd2;
   localparam logic [1:0] ST_FIND = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [LW-1:0]                   len_ff, len_in;
   logic [AW-1:0]                   rd_ff, rd_in;
   logic [AW-1:0]                   tgt_ff, tgt_in;
   logic                            more_ff, more_in;
   logic                            pend_ff, pend_in;
   logic [AW-1:0]                   pend_addr_ff, pend_addr_in;
   logic [oli_pkg::VALUE_W-1:0]     val_ff, val_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   oli_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   logic [oli_pkg::VALUE_W-1:0]     ram_wdata;
   logic                            ram_re;
   logic [oli_pkg::VALUE_W-1:0]     ram_rdata;

   logic [CW-1:0]                   len_w;
   logic [CW-1:0]                   pos_w;
   logic [CW-1:0]                   len_m1_w;
   logic [CW-1:0]                   pos_m1_w;
   logic [CW-1:0]                   hit_pos_w;

   // Resize a length or a position to the seven-bit field of the response.
   function automatic logic [oli_pkg::POS_W-1:0] to_field(input logic [LW-1:0] x);
      logic [CW-1:0] w;
      w = CW'(x);
      return w[oli_pkg::POS_W-1:0];
   endfunction

   // The element store: one word read and one word written per cycle.
   oli_ram #(
      .WIDTH (oli_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ff),
      .rd_data (ram_rdata)
   );

   assign len_w     = CW'(len_ff);
   assign pos_w     = CW'(req_data.position);
   assign len_m1_w  = len_w - CW'(1);
   assign pos_m1_w  = pos_w - CW'(1);
   assign hit_pos_w = CW'(pend_addr_ff) + CW'(1);

   // The sequencer walks the store with one address counter. Each cycle it
   // may issue one read; the word returns in the next cycle and is either written
   // one place up (insert), one place down (delete) or compared (find).
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rd_in        = rd_ff;
      tgt_in       = tgt_ff;
      more_in      = more_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = pend_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;

      // Read step, shared by all three walks. The walk ends once the target
      // address has been read.
      if ((state_ff != ST_IDLE) && more_ff) begin
         ram_re  = 1'b1;
         pend_in = 1'b1;
         more_in = (rd_ff != tgt_ff);
         unique case (state_ff)
            ST_INS: begin
               rd_in        = rd_ff - AW'(1);
               pend_addr_in = rd_ff + AW'(1);
            end
            ST_DEL: begin
               rd_in        = rd_ff + AW'(1);
               pend_addr_in = rd_ff - AW'(1);
            end
            default: begin
               rd_in        = rd_ff + AW'(1);
               pend_addr_in = rd_ff;
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // A rejected or unknown request answers at once with the
               // length unchanged; the fields below are overwritten when the
               // request is taken on.
               rsp_valid_in          = 1'b1;
               rsp_in.ok             = 1'b0;
               rsp_in.found_position = '0;
               rsp_in.list_count     = to_field(len_ff);
               unique case (req_data.opcode)
                  oli_pkg::OP_INSERT: begin
                     if ((pos_w != '0) && (pos_w <= len_w + CW'(1)) &&
                         (len_w < CW'(CAPACITY))) begin
                        rsp_valid_in = 1'b0;
                        val_in       = req_data.value;
                        tgt_in       = pos_m1_w[AW-1:0];
                        rd_in        = len_m1_w[AW-1:0];
                        more_in      = (pos_w <= len_w);
                        state_in     = ST_INS;
                     end
                  end
                  oli_pkg::OP_DELETE: begin
                     if ((pos_w != '0) && (pos_w <= len_w)) begin
                        rsp_valid_in = 1'b0;
                        rd_in        = pos_w[AW-1:0];
                        tgt_in       = len_m1_w[AW-1:0];
                        more_in      = (pos_w < len_w);
                        state_in     = ST_DEL;
                     end
                  end
                  oli_pkg::OP_FIND: begin
                     rsp_valid_in = 1'b0;
                     val_in       = req_data.value;
                     rd_in        = '0;
                     tgt_in       = len_m1_w[AW-1:0];
                     more_in      = (len_ff != '0);
                     state_in     = ST_FIND;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end else if (!more_ff) begin
               // All later words have moved up; drop the new word into place.
               ram_we                = 1'b1;
               ram_waddr             = tgt_ff;
               ram_wdata             = val_ff;
               len_in                = len_ff + LW'(1);
               rsp_valid_in          = 1'b1;
               rsp_in.ok             = 1'b1;
               rsp_in.found_position = '0;
               rsp_in.list_count     = to_field(len_ff + LW'(1));
               state_in              = ST_IDLE;
            end
         end

         ST_DEL: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end else if (!more_ff) begin
               len_in                = len_ff - LW'(1);
               rsp_valid_in          = 1'b1;
               rsp_in.ok             = 1'b1;
               rsp_in.found_position = '0;
               rsp_in.list_count     = to_field(len_ff - LW'(1));
               state_in              = ST_IDLE;
            end
         end

         default: begin
            // Find: compare the word that came back; the first hit ends the walk.
            if (pend_ff && (ram_rdata == val_ff)) begin
               more_in               = 1'b0;
               pend_in               = 1'b0;
               rsp_valid_in          = 1'b1;
               rsp_in.ok             = 1'b1;
               rsp_in.found_position = hit_pos_w[oli_pkg::POS_W-1:0];
               rsp_in.list_count     = to_field(len_ff);
               state_in              = ST_IDLE;
            end else if (!pend_ff && !more_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_in.ok             = 1'b0;
               rsp_in.found_position = '0;
               rsp_in.list_count     = to_field(len_ff);
               state_in              = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      tgt_ff       <= tgt_in;
      pend_addr_ff <= pend_addr_in;
      val_ff       <= val_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/oli_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module oli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/ordered_list_insert_delete_find_tb.sv
// ----------------------------------------------------------------------------
// Ordered list insert, delete and find testbench
// Sends insert, delete, find and unused-opcode request words to the list and
// checks every response word against a model of the list kept here. A short
// table of directed words comes first, and then several hundred random words
// that fill the list to capacity and drain it again, with random gaps.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_find_tb;

   localparam int CAPACITY     = 64;
   localparam int MAX_POS      = (1 << oli_pkg::POS_W) - 1;
   localparam int REQ_W        = $bits(oli_pkg::req_type);
   localparam int WORD_COUNT   = 700;
   // Long enough for the slowest word, which walks the whole store.
   localparam int DRAIN_CYCLES = CAPACITY + 8;
   localparam int CYCLE_LIMIT  = 1_000_000;

   // The block turns this opcode away; the package gives it no name.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      oli_pkg::req_type word;
      bit               typed;
      oli_pkg::rsp_type want;
   } stim_row_type;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   oli_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   oli_pkg::rsp_type rsp_data;

   // Our own copy of the list contents and length, kept in step with every
   // word that the block accepts.
   logic [oli_pkg::VALUE_W-1:0] list_words [CAPACITY];
   int                          list_len = 0;

   oli_pkg::rsp_type expected_outcomes [$];
   stim_row_type     directed_rows [$];
   int               error_count   = 0;
   int               cycle_count   = 0;
   int               steady_words  = 0;
   bit               filling       = 1'b1;

   ordered_list_insert_delete_find #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Applies one request word to the list and returns the response it must
   // give. A rejected insert or delete, and the unused opcode, change nothing.
   function automatic oli_pkg::rsp_type apply_list_op(oli_pkg::req_type word);
      oli_pkg::rsp_type r;
      int               pos;
      int               k;
      r   = '0;
      pos = int'(word.position);
      case (word.opcode)
         oli_pkg::OP_INSERT: begin
            if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
               for (k = list_len; k >= pos; k--) begin
                  list_words[k] = list_words[k - 1];
               end
               list_words[pos - 1] = word.value;
               list_len++;
               r.ok = 1'b1;
            end
         end
         oli_pkg::OP_DELETE: begin
            if (pos >= 1 && pos <= list_len) begin
               for (k = pos; k < list_len; k++) begin
                  list_words[k - 1] = list_words[k];
               end
               list_len--;
               r.ok = 1'b1;
            end
         end
         oli_pkg::OP_FIND: begin
            // The position field plays no part in a find.
            for (k = 0; k < list_len; k++) begin
               if (r.found_position == '0 && list_words[k] == word.value) begin
                  r.found_position = oli_pkg::POS_W'(k + 1);
               end
            end
            r.ok = (r.found_position != '0);
         end
         default: begin
         end
      endcase
      r.list_count = oli_pkg::POS_W'(list_len);
      return r;
   endfunction

   task automatic add_row(logic [1:0] op, int pos, logic [oli_pkg::VALUE_W-1:0] val,
                          bit typed, bit ok = 1'b0, int fpos = 0, int count = 0);
      stim_row_type row;
      row.word.opcode         = op;
      row.word.position       = oli_pkg::POS_W'(pos);
      row.word.value          = val;
      row.typed               = typed;
      row.want.ok             = ok;
      row.want.found_position = oli_pkg::POS_W'(fpos);
      row.want.list_count     = oli_pkg::POS_W'(count);
      directed_rows.push_back(row);
   endtask

   // Values lean towards the extremes and a small pool, so that finds meet
   // duplicates and the first of several matches is what counts.
   function automatic logic [oli_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 15);
      case (roll)
         0:       return '0;
         1:       return '1;
         2:       return {1'b1, {(oli_pkg::VALUE_W - 1){1'b0}}};
         3:       return {1'b0, {(oli_pkg::VALUE_W - 1){1'b1}}};
         4, 5, 6: return oli_pkg::VALUE_W'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   // Positions from 1 to top are in range; now and then one outside is sent.
   function automatic int pick_position(int top);
      if (top >= 1 && $urandom_range(0, 9) != 0) begin
         return $urandom_range(1, top);
      end
      if ($urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(top + 1, MAX_POS);
   endfunction

   // Well-formed traffic for the most part: the list is filled until it is
   // full and then drained until it is empty, over and over, with finds for
   // values that are mostly present.
   function automatic oli_pkg::req_type make_random_word();
      oli_pkg::req_type word;
      int               roll;
      roll          = $urandom_range(0, 99);
      word.value    = pick_value();
      word.position = oli_pkg::POS_W'($urandom);
      if (roll < 2) begin
         word.opcode = OP_UNUSED;
         word.value  = $urandom;
      end else if (roll < 22) begin
         word.opcode = oli_pkg::OP_FIND;
         if (list_len > 0 && $urandom_range(0, 2) != 0) begin
            word.value = list_words[$urandom_range(0, list_len - 1)];
         end
      end else if (filling ? (roll < 88) : (roll < 34)) begin
         word.opcode   = oli_pkg::OP_INSERT;
         word.position = oli_pkg::POS_W'(pick_position(list_len + 1));
      end else begin
         word.opcode   = oli_pkg::OP_DELETE;
         word.position = oli_pkg::POS_W'(pick_position(list_len));
      end
      return word;
   endfunction

   // Mostly back-to-back or short gaps, a few long ones, and now and then a
   // stretch of words with no gap at all.
   function automatic int pick_gap();
      int roll;
      if (steady_words > 0) begin
         steady_words--;
         return 0;
      end
      if ($urandom_range(0, 59) == 0) begin
         steady_words = 30;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 80);
   endfunction

   // Offers a word from the falling edge on and holds it until a rising edge
   // finds the block not busy. The expectation is queued at that very edge.
   task automatic send_word(oli_pkg::req_type word, bit typed, oli_pkg::rsp_type want);
      oli_pkg::rsp_type predicted;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= word;
      do begin
         @(posedge clock);
      end while (busy);
      predicted = apply_list_op(word);
      expected_outcomes.push_back(typed ? want : predicted);
   endtask

   // Drops start for the given number of cycles; a gap of zero leaves it high
   // so that the next word follows straight on.
   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= REQ_W'({$urandom, $urandom});
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_responses();
      while (expected_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Every response word is checked against the oldest expectation.
   always @(posedge clock) begin : check_responses
      oli_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $error("response word with nothing expected: ok=%0d found_position=%0d list_count=%0d",
                   rsp_data.ok, rsp_data.found_position, rsp_data.list_count);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_data.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
               error_count++;
            end
            if (rsp_data.found_position !== want.found_position) begin
               $error("found_position: expected %0d, got %0d",
                      want.found_position, rsp_data.found_position);
               error_count++;
            end
            if (rsp_data.list_count !== want.list_count) begin
               $error("list_count: expected %0d, got %0d", want.list_count, rsp_data.list_count);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      oli_pkg::req_type word;
      oli_pkg::rsp_type unused_want;
      int               sent;

      // Directed words. An empty list first: every request there is turned
      // away. Then the extremes of the value range are inserted at the front,
      // in the middle and at the end, found again, and removed from both ends.
      add_row(oli_pkg::OP_FIND,   0,       32'd5,         1'b1, 1'b0, 0, 0);
      add_row(oli_pkg::OP_DELETE, 1,       32'd0,         1'b1, 1'b0, 0, 0);
      add_row(oli_pkg::OP_INSERT, 0,       32'd7,         1'b1, 1'b0, 0, 0);
      add_row(oli_pkg::OP_INSERT, 2,       32'd7,         1'b1, 1'b0, 0, 0);
      add_row(OP_UNUSED,          MAX_POS, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0);
      add_row(oli_pkg::OP_INSERT, 1,       32'h8000_0000, 1'b1, 1'b1, 0, 1);
      add_row(oli_pkg::OP_INSERT, 2,       32'h7FFF_FFFF, 1'b1, 1'b1, 0, 2);
      add_row(oli_pkg::OP_INSERT, 1,       32'h0000_0000, 1'b1, 1'b1, 0, 3);
      add_row(oli_pkg::OP_INSERT, 4,       32'hFFFF_FFFF, 1'b1, 1'b1, 0, 4);
      add_row(oli_pkg::OP_INSERT, MAX_POS, 32'h0000_1234, 1'b1, 1'b0, 0, 4);
      add_row(oli_pkg::OP_INSERT, 6,       32'h0000_1234, 1'b1, 1'b0, 0, 4);
      add_row(oli_pkg::OP_FIND,   0,       32'h8000_0000, 1'b0);
      add_row(oli_pkg::OP_FIND,   MAX_POS, 32'h7FFF_FFFF, 1'b0);
      add_row(oli_pkg::OP_FIND,   1,       32'hFFFF_FFFF, 1'b0);
      add_row(oli_pkg::OP_FIND,   2,       32'h0000_3039, 1'b1, 1'b0, 0, 4);
      // A second zero makes the next find report the first of the two.
      add_row(oli_pkg::OP_INSERT, 3,       32'h0000_0000, 1'b0);
      add_row(oli_pkg::OP_FIND,   5,       32'h0000_0000, 1'b0);
      add_row(oli_pkg::OP_DELETE, 0,       32'd0,         1'b1, 1'b0, 0, 5);
      add_row(oli_pkg::OP_DELETE, 6,       32'd0,         1'b1, 1'b0, 0, 5);
      add_row(oli_pkg::OP_DELETE, MAX_POS, 32'd0,         1'b1, 1'b0, 0, 5);
      add_row(oli_pkg::OP_DELETE, 5,       32'd0,         1'b0);
      add_row(oli_pkg::OP_DELETE, 1,       32'd0,         1'b0);
      add_row(oli_pkg::OP_FIND,   0,       32'h0000_0000, 1'b0);
      add_row(OP_UNUSED,          2,       32'h5555_AAAA, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
         idle_gap(pick_gap());
      end

      unused_want = '0;
      sent        = 0;
      while (sent < WORD_COUNT) begin
         word = make_random_word();
         send_word(word, 1'b0, unused_want);
         if (word.opcode != OP_UNUSED) begin
            sent++;
         end
         // Turn round only after a few words have met the full or empty list.
         if (filling && list_len == CAPACITY && $urandom_range(0, 3) == 0) begin
            filling = 1'b0;
         end else if (!filling && list_len == 0 && $urandom_range(0, 3) == 0) begin
            filling = 1'b1;
         end
         if (sent == WORD_COUNT / 2) begin
            // Hold off once until the block has answered everything.
            @(negedge clock);
            start <= 1'b0;
            wait_for_responses();
         end else begin
            idle_gap(pick_gap());
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
